// ----- rtl/core/tas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tas_pkg;

    localparam int unsigned SCAN_W   = 200;
    localparam int unsigned RESULT_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TMO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL_PERSIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_PERSIST = 3'd5;

    localparam logic [11:0] SETPOINT_RST      = 12'd0;
    localparam logic [7:0]  BAND_HALF_RST     = 8'd5;
    localparam logic [15:0] SETTLE_TMO_RST    = 16'd38000;
    localparam logic [9:0]  LAMP_LIMIT_RST    = 10'd14;
    localparam logic [7:0]  DUAL_PERSIST_RST  = 8'd10;
    localparam logic [7:0]  SINGLE_PERSIST_RST = 8'd15;

    localparam logic [7:0] BYTE_ONES = 8'hff;

    typedef struct packed {
        logic [11:0] setpoint;
        logic [7:0]  band_half_width;
        logic [15:0] settle_timeout;
        logic [9:0]  lamp_imbalance_limit;
        logic [7:0]  dual_fault_persist;
        logic [7:0]  single_fault_persist;
    } cfg_t;

    typedef struct packed {
        logic [63:0]        sensor_a_head;
        logic [7:0]         sensor_a_tail;
        logic [63:0]        sensor_b_head;
        logic [7:0]         sensor_b_tail;
        logic signed [11:0] temperature;
        logic [15:0]        elapsed_time;
        logic [9:0]         lamp_a_level;
        logic [9:0]         lamp_b_level;
        logic               ext_fault_a;
        logic               ext_fault_b;
        logic               auto_mode;
    } scan_t;

    // per-scan conditions, no state involved
    typedef struct packed {
        logic bad_a;
        logic bad_b;
        logic fault_a;
        logic fault_b;
        logic in_range;
        logic over_cond;
        logic under_cond;
        logic lamp_a_gt;
        logic lamp_b_gt;
        logic lamp_over;
        logic auto_on;
    } cls_t;

    typedef struct packed {
        logic [1:0] read_faults;
        logic       in_band;
        logic       over_temp;
        logic       under_temp;
        logic       temp_pilot;
        logic [1:0] lamp_faults;
        logic       sensor_a_alarm;
        logic       sensor_b_alarm;
        logic       dual_sensor_alarm;
        logic       sensor_pilot;
        logic       clear_elapsed;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tas_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tas_classify
(
    input  wire tas_pkg::scan_t scan,
    input  wire tas_pkg::cfg_t  cfg,
    output tas_pkg::cls_t       cls
);

    logic               bad_a;
    logic               bad_b;
    logic signed [13:0] temp_ext;
    logic signed [13:0] sp_ext;
    logic signed [13:0] bw_ext;
    logic signed [13:0] upper;
    logic signed [13:0] lower;
    logic               timed_out;
    logic [9:0]         lamp_diff;

    always_comb
    begin
        bad_a = (scan.sensor_a_head == '0 && scan.sensor_a_tail == '0)
             || (scan.sensor_a_head == '1 && scan.sensor_a_tail == tas_pkg::BYTE_ONES)
             || (scan.sensor_a_head[7:0] == tas_pkg::BYTE_ONES
                 && scan.sensor_a_head[15:8] == 8'd0);
        bad_b = (scan.sensor_b_head == '0 && scan.sensor_b_tail == '0)
             || (scan.sensor_b_head == '1 && scan.sensor_b_tail == tas_pkg::BYTE_ONES)
             || (scan.sensor_b_head[7:0] == tas_pkg::BYTE_ONES
                 && scan.sensor_b_head[15:8] == 8'd0);

        // band edges around half the setpoint
        temp_ext  = {{2{scan.temperature[11]}}, scan.temperature};
        sp_ext    = {3'b000, cfg.setpoint[11:1]};
        bw_ext    = {6'b000000, cfg.band_half_width};
        upper     = sp_ext + bw_ext;
        lower     = sp_ext - bw_ext;
        timed_out = scan.elapsed_time > cfg.settle_timeout;

        if (scan.lamp_a_level > scan.lamp_b_level)
        begin
            lamp_diff = scan.lamp_a_level - scan.lamp_b_level;
        end
        else
        begin
            lamp_diff = scan.lamp_b_level - scan.lamp_a_level;
        end

        cls.bad_a      = bad_a;
        cls.bad_b      = bad_b;
        cls.fault_a    = bad_a | scan.ext_fault_a;
        cls.fault_b    = bad_b | scan.ext_fault_b;
        cls.in_range   = (temp_ext < upper) && (temp_ext > lower);
        cls.over_cond  = (temp_ext > upper) && timed_out;
        cls.under_cond = (temp_ext < lower) && timed_out;
        cls.lamp_a_gt  = scan.lamp_a_level > scan.lamp_b_level;
        cls.lamp_b_gt  = scan.lamp_b_level > scan.lamp_a_level;
        cls.lamp_over  = lamp_diff > cfg.lamp_imbalance_limit;
        cls.auto_on    = scan.auto_mode;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tas_alarm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tas_alarm
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  wire tas_pkg::cls_t  cls,
    input  wire tas_pkg::cfg_t  cfg,
    output tas_pkg::result_t    result
);

    logic       over_reg,         over_next;
    logic       under_reg,        under_next;
    logic       temp_pilot_reg,   temp_pilot_next;
    logic [1:0] lamp_reg,         lamp_next;
    logic       sensor_pilot_reg, sensor_pilot_next;
    logic [8:0] dual_cnt_reg,     dual_cnt_next;
    logic [8:0] a_cnt_reg,        a_cnt_next;
    logic [8:0] b_cnt_reg,        b_cnt_next;

    logic [8:0] dual_lim;
    logic [8:0] single_lim;
    logic       dual_cond;
    logic       dual_alarm;
    logic       alarm_a;
    logic       alarm_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_reg         <= 1'b0;
            under_reg        <= 1'b0;
            temp_pilot_reg   <= 1'b0;
            lamp_reg         <= 2'b00;
            sensor_pilot_reg <= 1'b0;
            dual_cnt_reg     <= '0;
            a_cnt_reg        <= '0;
            b_cnt_reg        <= '0;
        end
        else if (step)
        begin
            over_reg         <= over_next;
            under_reg        <= under_next;
            temp_pilot_reg   <= temp_pilot_next;
            lamp_reg         <= lamp_next;
            sensor_pilot_reg <= sensor_pilot_next;
            dual_cnt_reg     <= dual_cnt_next;
            a_cnt_reg        <= a_cnt_next;
            b_cnt_reg        <= b_cnt_next;
        end
    end

    always_comb
    begin
        dual_lim   = {1'b0, cfg.dual_fault_persist};
        single_lim = {1'b0, cfg.single_fault_persist};
        dual_cond  = cls.fault_a & cls.fault_b;

        // persistence counters hold at limit + 1 once past the limit
        if (!dual_cond)
        begin
            dual_cnt_next = '0;
        end
        else if (dual_cnt_reg > dual_lim)
        begin
            dual_cnt_next = dual_lim + 9'd1;
        end
        else
        begin
            dual_cnt_next = dual_cnt_reg + 9'd1;
        end
        dual_alarm = dual_cond && (dual_cnt_next > dual_lim);

        if (!cls.fault_a)
        begin
            a_cnt_next = '0;
        end
        else if (a_cnt_reg > single_lim)
        begin
            a_cnt_next = single_lim + 9'd1;
        end
        else
        begin
            a_cnt_next = a_cnt_reg + 9'd1;
        end
        alarm_a = cls.fault_a && (a_cnt_next > single_lim);

        if (!cls.fault_b)
        begin
            b_cnt_next = '0;
        end
        else if (b_cnt_reg > single_lim)
        begin
            b_cnt_next = single_lim + 9'd1;
        end
        else
        begin
            b_cnt_next = b_cnt_reg + 9'd1;
        end
        alarm_b = cls.fault_b && (b_cnt_next > single_lim);

        // temperature alarms; on a band edge they keep their values
        over_next       = over_reg;
        under_next      = under_reg;
        temp_pilot_next = temp_pilot_reg;
        if (cls.in_range)
        begin
            over_next  = 1'b0;
            under_next = 1'b0;
        end
        if (cls.over_cond)
        begin
            over_next       = 1'b1;
            under_next      = 1'b0;
            temp_pilot_next = 1'b1;
        end
        if (cls.under_cond)
        begin
            under_next      = 1'b1;
            over_next       = 1'b0;
            temp_pilot_next = 1'b1;
        end
        if (cls.auto_on)
        begin
            over_next       = 1'b0;
            under_next      = 1'b0;
            temp_pilot_next = 1'b0;
        end

        // lamp flags: equal levels keep the flags
        lamp_next = lamp_reg;
        if (!cls.fault_a && !cls.fault_b)
        begin
            if (cls.lamp_a_gt)
            begin
                lamp_next = {cls.lamp_over, 1'b0};
            end
            else if (cls.lamp_b_gt)
            begin
                lamp_next = {1'b0, cls.lamp_over};
            end
        end
        if (alarm_a || alarm_b)
        begin
            lamp_next = 2'b00;
        end

        sensor_pilot_next = sensor_pilot_reg | dual_alarm;

        result.read_faults       = {cls.bad_b, cls.bad_a};
        result.in_band           = cls.in_range & ~cls.auto_on;
        result.over_temp         = over_next;
        result.under_temp        = under_next;
        result.temp_pilot        = temp_pilot_next;
        result.lamp_faults       = lamp_next;
        result.sensor_a_alarm    = alarm_a;
        result.sensor_b_alarm    = alarm_b;
        result.dual_sensor_alarm = dual_alarm;
        result.sensor_pilot      = sensor_pilot_next;
        result.clear_elapsed     = cls.in_range | cls.auto_on;
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(over_reg && under_reg))
        else $error("over and under alarms both latched");

    assert property (@(posedge clk) disable iff (!rst_n)
        (over_reg || under_reg) |-> temp_pilot_reg)
        else $error("temperature alarm without pilot");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(sensor_pilot_reg) |-> sensor_pilot_reg)
        else $error("sensor pilot cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && dual_alarm) |=> sensor_pilot_reg)
        else $error("dual alarm did not set sensor pilot");

endmodule

`default_nettype wire

// ----- rtl/core/temperature_alarm_supervisor_core.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata[199:0], one scan word
// m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata[15:0], one result word
// cfg       in   cfg_wr_en                     cfg_index[2:0], cfg_wdata[15:0]
//
// One result word per scan word; a new scan word is taken every cycle unless
// m_axis stalls with both registers full. Input register, then compare/count
// logic into the result register, which also updates the alarm state.
// rst_n clears valids, alarm state and configuration to defaults.
// A stall on m_axis holds the result; the input register keeps filling
// until it too is full, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module temperature_alarm_supervisor_core
(
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [63:0] sensor_a_head, [71:64] sensor_a_tail, [135:72] sensor_b_head,
    // [143:136] sensor_b_tail, [155:144] temperature, [171:156] elapsed_time,
    // [181:172] lamp_a_level, [191:182] lamp_b_level, [192] ext_fault_a,
    // [193] ext_fault_b, [194] auto_mode, [199:195] zero
    input  wire [tas_pkg::SCAN_W-1:0]            s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [1:0] read_faults, [2] in_band, [3] over_temp, [4] under_temp,
    // [5] temp_pilot, [7:6] lamp_faults, [8] sensor_a_alarm,
    // [9] sensor_b_alarm, [10] dual_sensor_alarm, [11] sensor_pilot,
    // [12] clear_elapsed, [15:13] zero
    output logic [tas_pkg::RESULT_W-1:0]         m_axis_tdata,

    input  wire                                  cfg_wr_en,
    input  wire [tas_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [tas_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    tas_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [194:0]     in_data_reg;
    logic             out_valid_reg;
    tas_pkg::result_t out_data_reg;

    tas_pkg::scan_t   scan;
    tas_pkg::cls_t    cls;
    tas_pkg::result_t result;
    logic             in_accept;
    logic             out_free;
    logic             advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint             <= tas_pkg::SETPOINT_RST;
            cfg_reg.band_half_width      <= tas_pkg::BAND_HALF_RST;
            cfg_reg.settle_timeout       <= tas_pkg::SETTLE_TMO_RST;
            cfg_reg.lamp_imbalance_limit <= tas_pkg::LAMP_LIMIT_RST;
            cfg_reg.dual_fault_persist   <= tas_pkg::DUAL_PERSIST_RST;
            cfg_reg.single_fault_persist <= tas_pkg::SINGLE_PERSIST_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tas_pkg::REG_SETPOINT:       cfg_reg.setpoint <= cfg_wdata[11:0];
                tas_pkg::REG_BAND_HALF:      cfg_reg.band_half_width <= cfg_wdata[7:0];
                tas_pkg::REG_SETTLE_TMO:     cfg_reg.settle_timeout <= cfg_wdata;
                tas_pkg::REG_LAMP_LIMIT:     cfg_reg.lamp_imbalance_limit <= cfg_wdata[9:0];
                tas_pkg::REG_DUAL_PERSIST:   cfg_reg.dual_fault_persist <= cfg_wdata[7:0];
                tas_pkg::REG_SINGLE_PERSIST: cfg_reg.single_fault_persist <= cfg_wdata[7:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_axis_tdata[194:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign scan.sensor_a_head = in_data_reg[63:0];
    assign scan.sensor_a_tail = in_data_reg[71:64];
    assign scan.sensor_b_head = in_data_reg[135:72];
    assign scan.sensor_b_tail = in_data_reg[143:136];
    assign scan.temperature   = in_data_reg[155:144];
    assign scan.elapsed_time  = in_data_reg[171:156];
    assign scan.lamp_a_level  = in_data_reg[181:172];
    assign scan.lamp_b_level  = in_data_reg[191:182];
    assign scan.ext_fault_a   = in_data_reg[192];
    assign scan.ext_fault_b   = in_data_reg[193];
    assign scan.auto_mode     = in_data_reg[194];

    tas_classify u_classify
    (
        .scan (scan),
        .cfg  (cfg_reg),
        .cls  (cls)
    );

    tas_alarm u_alarm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cls    (cls),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_data_reg.clear_elapsed,
                            out_data_reg.sensor_pilot,
                            out_data_reg.dual_sensor_alarm,
                            out_data_reg.sensor_b_alarm,
                            out_data_reg.sensor_a_alarm,
                            out_data_reg.lamp_faults,
                            out_data_reg.temp_pilot,
                            out_data_reg.under_temp,
                            out_data_reg.over_temp,
                            out_data_reg.in_band,
                            out_data_reg.read_faults};

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held scan word dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed scan word produced no result");

endmodule

`default_nettype wire

// ----- tb/tb_temperature_alarm_supervisor_core.sv -----
`timescale 1ns / 1ps

module tb_temperature_alarm_supervisor_core;

    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {PAD_GOOD, PAD_ZERO, PAD_ONES, PAD_FF00, PAD_NEAR, PAD_NOISE} pad_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [tas_pkg::SCAN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [tas_pkg::RESULT_W-1:0] m_axis_tdata;
    logic cfg_wr_en = 1'b0;
    logic [tas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    tas_pkg::cfg_t cfg;
    bit over_q;
    bit under_q;
    bit temp_pilot_q;
    bit sensor_pilot_q;
    bit [1:0] lamp_q;
    int dual_cnt;
    int a_cnt;
    int b_cnt;

    tas_pkg::result_t results_due[$];
    int mismatch_count = 0;
    int cycles = 0;
    bit no_idle = 1'b0;
    int rx_wait = 0;

    temperature_alarm_supervisor_core DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_temperature_alarm_supervisor_core failed");
            $finish;
        end
    end

    // result side: random stall after each word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wait = 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_wait = no_idle ? 0 : int'($urandom_range(0, 5));
            else if (rx_wait > 0)
                rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic tas_pkg::result_t unpack_result(
        input logic [tas_pkg::RESULT_W-1:0] d);
        tas_pkg::result_t r;
        r.read_faults = d[1:0];
        r.in_band = d[2];
        r.over_temp = d[3];
        r.under_temp = d[4];
        r.temp_pilot = d[5];
        r.lamp_faults = d[7:6];
        r.sensor_a_alarm = d[8];
        r.sensor_b_alarm = d[9];
        r.dual_sensor_alarm = d[10];
        r.sensor_pilot = d[11];
        r.clear_elapsed = d[12];
        return r;
    endfunction

    always @(posedge clk)
    begin
        tas_pkg::result_t got;
        tas_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
            else
            begin
                got = unpack_result(m_axis_tdata);
                want = results_due.pop_front();
                compare_field("read_faults", int'(got.read_faults), int'(want.read_faults));
                compare_field("in_band", int'(got.in_band), int'(want.in_band));
                compare_field("over_temp", int'(got.over_temp), int'(want.over_temp));
                compare_field("under_temp", int'(got.under_temp), int'(want.under_temp));
                compare_field("temp_pilot", int'(got.temp_pilot), int'(want.temp_pilot));
                compare_field("lamp_faults", int'(got.lamp_faults), int'(want.lamp_faults));
                compare_field("sensor_a_alarm", int'(got.sensor_a_alarm),
                              int'(want.sensor_a_alarm));
                compare_field("sensor_b_alarm", int'(got.sensor_b_alarm),
                              int'(want.sensor_b_alarm));
                compare_field("dual_sensor_alarm", int'(got.dual_sensor_alarm),
                              int'(want.dual_sensor_alarm));
                compare_field("sensor_pilot", int'(got.sensor_pilot), int'(want.sensor_pilot));
                compare_field("clear_elapsed", int'(got.clear_elapsed),
                              int'(want.clear_elapsed));
            end
        end
    end

    function automatic bit pad_bad(input logic [63:0] head, input logic [7:0] tail);
        return (head == '0 && tail == '0) || (head == '1 && tail == tas_pkg::BYTE_ONES)
            || (head[7:0] == tas_pkg::BYTE_ONES && head[15:8] == 8'h00);
    endfunction

    function automatic bit persist_step(inout int cnt, input bit cond, input int lim);
        if (!cond)
        begin
            cnt = 0;
            return 1'b0;
        end
        if (cnt > lim)
            cnt = lim + 1;
        else
            cnt++;
        return cnt > lim;
    endfunction

    function automatic tas_pkg::result_t supervise_scan(input tas_pkg::scan_t s);
        int t;
        int sp;
        int bw;
        int diff;
        bit bad_a;
        bit bad_b;
        bit fa;
        bit fb;
        bit in_range;
        bit timed_out;
        bit dual;
        bit al_a;
        bit al_b;
        tas_pkg::result_t r;
        bad_a = pad_bad(s.sensor_a_head, s.sensor_a_tail);
        bad_b = pad_bad(s.sensor_b_head, s.sensor_b_tail);
        fa = bad_a || s.ext_fault_a;
        fb = bad_b || s.ext_fault_b;
        t = {{20{s.temperature[11]}}, s.temperature};
        sp = int'(cfg.setpoint >> 1);
        bw = int'(cfg.band_half_width);
        in_range = (t < sp + bw) && (t > sp - bw);
        timed_out = s.elapsed_time > cfg.settle_timeout;
        r = '0;
        r.in_band = in_range;
        r.clear_elapsed = in_range;
        if (in_range)
        begin
            over_q = 1'b0;
            under_q = 1'b0;
        end
        if (!fa && !fb)
        begin
            if (s.lamp_a_level > s.lamp_b_level)
            begin
                diff = int'(s.lamp_a_level) - int'(s.lamp_b_level);
                lamp_q[0] = 1'b0;
                lamp_q[1] = diff > int'(cfg.lamp_imbalance_limit);
            end
            else if (s.lamp_b_level > s.lamp_a_level)
            begin
                diff = int'(s.lamp_b_level) - int'(s.lamp_a_level);
                lamp_q[1] = 1'b0;
                lamp_q[0] = diff > int'(cfg.lamp_imbalance_limit);
            end
        end
        if (t > sp + bw && timed_out)
        begin
            over_q = 1'b1;
            under_q = 1'b0;
            temp_pilot_q = 1'b1;
        end
        if (t < sp - bw && timed_out)
        begin
            under_q = 1'b1;
            over_q = 1'b0;
            temp_pilot_q = 1'b1;
        end
        if (s.auto_mode)
        begin
            over_q = 1'b0;
            under_q = 1'b0;
            temp_pilot_q = 1'b0;
            r.in_band = 1'b0;
            r.clear_elapsed = 1'b1;
        end
        dual = persist_step(dual_cnt, fa && fb, int'(cfg.dual_fault_persist));
        if (dual)
            sensor_pilot_q = 1'b1;
        al_b = persist_step(b_cnt, fb, int'(cfg.single_fault_persist));
        al_a = persist_step(a_cnt, fa, int'(cfg.single_fault_persist));
        if (al_a || al_b)
            lamp_q = 2'b00;
        r.read_faults = {bad_b, bad_a};
        r.over_temp = over_q;
        r.under_temp = under_q;
        r.temp_pilot = temp_pilot_q;
        r.lamp_faults = lamp_q;
        r.sensor_a_alarm = al_a;
        r.sensor_b_alarm = al_b;
        r.dual_sensor_alarm = dual;
        r.sensor_pilot = sensor_pilot_q;
        return r;
    endfunction

    function automatic logic [tas_pkg::SCAN_W-1:0] pack_scan(input tas_pkg::scan_t s);
        return {5'b0, s.auto_mode, s.ext_fault_b, s.ext_fault_a, s.lamp_b_level,
                s.lamp_a_level, s.elapsed_time, s.temperature, s.sensor_b_tail,
                s.sensor_b_head, s.sensor_a_tail, s.sensor_a_head};
    endfunction

    task automatic send_scan(input tas_pkg::scan_t s);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_scan(s);
        do
            @(posedge clk);
        while (!s_axis_tready);
        results_due.push_back(supervise_scan(s));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tas_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            tas_pkg::REG_SETPOINT:       cfg.setpoint = value[11:0];
            tas_pkg::REG_BAND_HALF:      cfg.band_half_width = value[7:0];
            tas_pkg::REG_SETTLE_TMO:     cfg.settle_timeout = value;
            tas_pkg::REG_LAMP_LIMIT:     cfg.lamp_imbalance_limit = value[9:0];
            tas_pkg::REG_DUAL_PERSIST:   cfg.dual_fault_persist = value[7:0];
            tas_pkg::REG_SINGLE_PERSIST: cfg.single_fault_persist = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input tas_pkg::cfg_t c);
        drain_results();
        write_reg(tas_pkg::REG_SETPOINT, 16'(c.setpoint));
        write_reg(tas_pkg::REG_BAND_HALF, 16'(c.band_half_width));
        write_reg(tas_pkg::REG_SETTLE_TMO, c.settle_timeout);
        write_reg(tas_pkg::REG_LAMP_LIMIT, 16'(c.lamp_imbalance_limit));
        write_reg(tas_pkg::REG_DUAL_PERSIST, 16'(c.dual_fault_persist));
        write_reg(tas_pkg::REG_SINGLE_PERSIST, 16'(c.single_fault_persist));
    endtask

    function automatic void make_pad(input pad_kind_t kind, output logic [63:0] head,
                                     output logic [7:0] tail);
        logic [71:0] v;
        head = {$urandom, $urandom};
        tail = 8'($urandom_range(0, 255));
        case (kind)
            PAD_GOOD:
                if (pad_bad(head, tail))
                    head[15:0] = 16'h0112;
            PAD_ZERO:
            begin
                head = '0;
                tail = '0;
            end
            PAD_ONES:
            begin
                head = '1;
                tail = tas_pkg::BYTE_ONES;
            end
            PAD_FF00:
                head[15:0] = {8'h00, tas_pkg::BYTE_ONES};
            PAD_NEAR:
            begin
                // one bit away from an all-zero or all-ones pad
                v = $urandom_range(0, 1) ? '1 : '0;
                v[$urandom_range(0, 71)] ^= 1'b1;
                head = v[63:0];
                tail = v[71:64];
            end
            default: ;
        endcase
    endfunction

    function automatic tas_pkg::scan_t corner_scan(input pad_kind_t ka, input pad_kind_t kb,
                                                   input bit ea, input bit eb, input int t,
                                                   input int el, input int la, input int lb,
                                                   input bit auto_on);
        tas_pkg::scan_t s;
        make_pad(ka, s.sensor_a_head, s.sensor_a_tail);
        make_pad(kb, s.sensor_b_head, s.sensor_b_tail);
        s.ext_fault_a = ea;
        s.ext_fault_b = eb;
        s.temperature = t[11:0];
        s.elapsed_time = el[15:0];
        s.lamp_a_level = la[9:0];
        s.lamp_b_level = lb[9:0];
        s.auto_mode = auto_on;
        return s;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic tas_pkg::scan_t random_scan(input pad_kind_t ka, input pad_kind_t kb,
                                                   input bit ea, input bit eb);
        int sp;
        int bw;
        int lim;
        int t;
        int el;
        int la;
        int lb;
        sp = int'(cfg.setpoint >> 1);
        bw = int'(cfg.band_half_width);
        lim = int'(cfg.lamp_imbalance_limit);
        if ($urandom_range(0, 9) < 7)
            t = sp + int'($urandom_range(0, 2 * bw + 6)) - (bw + 3);
        else
            t = int'($urandom_range(0, 3071)) - 1024;
        t = clamp(t, -1024, 2047);
        if ($urandom_range(0, 1))
            el = clamp(int'(cfg.settle_timeout) + int'($urandom_range(0, 4)) - 2, 0, 65535);
        else
            el = int'($urandom_range(0, 65535));
        la = int'($urandom_range(0, 1023));
        if ($urandom_range(0, 1))
            lb = clamp(la + int'($urandom_range(0, 2 * lim + 4)) - (lim + 2), 0, 1023);
        else
            lb = int'($urandom_range(0, 1023));
        return corner_scan(ka, kb, ea, eb, t, el, la, lb, $urandom_range(0, 11) == 0);
    endfunction

    function automatic pad_kind_t pick_kind();
        case ($urandom_range(0, 9))
            5: return PAD_ZERO;
            6: return PAD_ONES;
            7: return PAD_FF00;
            8: return PAD_NEAR;
            9: return PAD_NOISE;
            default: return PAD_GOOD;
        endcase
    endfunction

    function automatic tas_pkg::cfg_t random_cfg();
        tas_pkg::cfg_t c;
        c.setpoint = 12'($urandom_range(0, 4095));
        c.band_half_width = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 30))
                                                         : 8'($urandom_range(0, 255));
        c.settle_timeout = 16'($urandom_range(0, 65535));
        c.lamp_imbalance_limit = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 40))
                                                              : 10'($urandom_range(0, 1023));
        c.dual_fault_persist = 8'($urandom_range(0, 20));
        c.single_fault_persist = 8'($urandom_range(0, 20));
        return c;
    endfunction

    // runs of held sensor conditions so the persistence counters get exercised
    task automatic run_random(input int count);
        int sent;
        int run_len;
        int longest;
        pad_kind_t ka;
        pad_kind_t kb;
        bit ea;
        bit eb;
        sent = 0;
        longest = (cfg.single_fault_persist > cfg.dual_fault_persist)
                ? int'(cfg.single_fault_persist) : int'(cfg.dual_fault_persist);
        while (sent < count)
        begin
            ka = pick_kind();
            kb = pick_kind();
            ea = ($urandom_range(0, 7) == 0);
            eb = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0)
                run_len = longest + int'($urandom_range(1, 6));
            else
                run_len = int'($urandom_range(1, 4));
            repeat (run_len)
            begin
                send_scan(random_scan(ka, kb, ea, eb));
                sent++;
            end
            if ($urandom_range(0, 15) == 0)
                no_idle = ~no_idle;
            if ($urandom_range(0, 40) == 0)
                drain_results();
        end
    endtask

    task automatic test_reset_corners();
        // default settings: band 5 around zero, timeout 38000, lamp limit 14
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 0, 0, 100, 100, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 5, 65535, 200, 185, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, -5, 38000, 185, 200, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 6, 38000, 0, 14, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 6, 38001, 300, 300, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 5, 0, 14, 0, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, 2047, 65535, 1023, 0, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, -1024, 65535, 0, 1023, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, -6, 38001, 10, 500, 1));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 0, -6, 38001, 500, 10, 0));
        send_scan(corner_scan(PAD_ZERO, PAD_ONES, 0, 0, 4, 100, 0, 900, 0));
        send_scan(corner_scan(PAD_FF00, PAD_GOOD, 0, 0, -4, 100, 900, 0, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_FF00, 0, 0, 7, 65535, 3, 700, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 1, 0, 0, 0, 700, 3, 0));
        send_scan(corner_scan(PAD_GOOD, PAD_GOOD, 0, 1, 0, 0, 700, 3, 0));
        send_scan(corner_scan(PAD_NEAR, PAD_NEAR, 0, 0, 1, 1, 40, 20, 0));
        send_scan(corner_scan(PAD_ONES, PAD_ONES, 1, 1, 2047, 65535, 1023, 1023, 1));
        send_scan(corner_scan(PAD_ZERO, PAD_ZERO, 0, 0, -1024, 0, 0, 0, 0));
        send_scan(corner_scan(PAD_NOISE, PAD_NOISE, 0, 0, -1, 38001, 512, 511, 0));
        drain_results();
    endtask

    task automatic test_threshold_change();
        tas_pkg::cfg_t c;
        c = cfg;
        c.single_fault_persist = 8'd15;
        c.dual_fault_persist = 8'd10;
        apply_config(c);
        repeat (12) send_scan(random_scan(PAD_ZERO, PAD_ONES, 0, 0));
        drain_results();
        // counters already above the new, lower thresholds
        write_reg(tas_pkg::REG_SINGLE_PERSIST, 16'd3);
        write_reg(tas_pkg::REG_DUAL_PERSIST, 16'd4);
        repeat (4) send_scan(random_scan(PAD_ZERO, PAD_GOOD, 0, 1));
        drain_results();
        write_reg(tas_pkg::REG_SINGLE_PERSIST, 16'd200);
        repeat (3) send_scan(random_scan(PAD_FF00, PAD_GOOD, 0, 0));
        drain_results();
    endtask

    task automatic test_random_settings();
        tas_pkg::cfg_t c;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: c = '0;
                1: c = '1;
                default: c = random_cfg();
            endcase
            apply_config(c);
            no_idle = (phase == 3);
            run_random(300);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        cfg.setpoint = tas_pkg::SETPOINT_RST;
        cfg.band_half_width = tas_pkg::BAND_HALF_RST;
        cfg.settle_timeout = tas_pkg::SETTLE_TMO_RST;
        cfg.lamp_imbalance_limit = tas_pkg::LAMP_LIMIT_RST;
        cfg.dual_fault_persist = tas_pkg::DUAL_PERSIST_RST;
        cfg.single_fault_persist = tas_pkg::SINGLE_PERSIST_RST;
        over_q = 1'b0;
        under_q = 1'b0;
        temp_pilot_q = 1'b0;
        sensor_pilot_q = 1'b0;
        lamp_q = 2'b00;
        dual_cnt = 0;
        a_cnt = 0;
        b_cnt = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_corners();
        test_threshold_change();
        test_random_settings();
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_temperature_alarm_supervisor_core passed");
        else
            $display("tb_temperature_alarm_supervisor_core failed");
        $finish;
    end

endmodule
